// File: src/rwct_pkg.sv
// ----------------------------------------------------------------------------
// rwct_pkg
// shared types and constants of the textured wall column block
// ----------------------------------------------------------------------------
package rwct_pkg;

  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int SCREEN_WIDTH_DEF  = 256;
  localparam int TEX_SIZE          = 64;
  localparam int TEX_AW            = 12;
  localparam int STORE_AW          = 14;
  localparam int IDX_W             = 14;
  localparam logic [31:0] WALL_SCALE_RST = 32'd16384;
  localparam logic [15:0] HEIGHT_MAX     = 16'hffff;
  // reciprocal of 5 in 2^-18 units, exact for 15-bit operands
  localparam logic [15:0] SHADE_RECIP    = 16'd52429;
  localparam logic [7:0]  ALPHA          = 8'hff;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_HDIV,
    ST_CLIP,
    ST_SETUP,
    ST_RDIV,
    ST_READ,
    ST_EMIT
  } state_t;

  // shared divider op request
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [24:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

// File: src/rwct_if.sv
// ----------------------------------------------------------------------------
// rwct_in_if / rwct_out_if
// valid/ready channels of the textured wall column block
// ----------------------------------------------------------------------------
interface rwct_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [1:0]  tex_id;
  logic [11:0] tex_addr;
  logic [23:0] texel_rgb;
  logic [7:0]  screen_column;
  logic [23:0] ray_distance;
  logic [15:0] cos_factor;
  logic [15:0] hit_coord;
  logic        side_vertical;
  logic [2:0]  quadrant;
  modport source (output valid, func, tex_id, tex_addr, texel_rgb, screen_column,
                  ray_distance, cos_factor, hit_coord, side_vertical, quadrant,
                  input ready);
  modport sink (input valid, func, tex_id, tex_addr, texel_rgb, screen_column,
                ray_distance, cos_factor, hit_coord, side_vertical, quadrant,
                output ready);
endinterface

interface rwct_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] pixel_index;
  logic [31:0] pixel_rgba;
  logic        last_pixel;
  modport source (output valid, pixel_index, pixel_rgba, last_pixel, input ready);
  modport sink (input valid, pixel_index, pixel_rgba, last_pixel, output ready);
endinterface

// File: src/rwct_div.sv
// ----------------------------------------------------------------------------
// rwct_div
// shared restoring divider, one quotient bit per cycle, 32 by 25 bits
// ----------------------------------------------------------------------------
module rwct_div (
  input  logic               clk,
  input  logic               rst,
  input  rwct_pkg::div_req_t req,
  output rwct_pkg::div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [31:0] quo;
  logic [25:0] rem;
  logic [24:0] den;
  logic [25:0] trial;

  assign trial = {rem[24:0], quo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) busy && cnt != 6'd31 |=> busy)
    else $error("divider stopped early");
  assert property (@(posedge clk) disable iff (rst) req.start |=> busy && cnt == 6'd0)
    else $error("divider did not start");

endmodule

// File: src/rwct_store.sv
// ----------------------------------------------------------------------------
// rwct_store
// texture memory, four 64x64 textures of 24-bit texels
// ----------------------------------------------------------------------------
module rwct_store (
  input  logic                          clk,
  input  logic                          we,
  input  logic [rwct_pkg::STORE_AW-1:0] waddr,
  input  logic [23:0]                   wdata,
  input  logic [rwct_pkg::STORE_AW-1:0] raddr,
  output logic [23:0]                   rdata
);

  logic [23:0] mem [0:(1 << rwct_pkg::STORE_AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/raycast_wall_column_texturer_core.sv
// ----------------------------------------------------------------------------
// raycast_wall_column_texturer_core
// textured wall column renderer for a ray caster
// ----------------------------------------------------------------------------
// requests arrive on in_ch; a load request writes one texel. a draw
// request corrects the distance (a registered multiply), divides
// wall_scale by it (a pass of the shared divider, skipped for zero
// distance), clips the slice and derives the shade by a reciprocal
// multiply, then emits one pixel per covered row on out_ch, top row
// first, with last_pixel on the final one. each pixel takes a texture
// row division, a memory read and an output step, so the time for a
// full column is set by the one shared divider. in_ch.ready is high only
// while idle. a stalled receiver holds the pixel in the output register;
// the sequencer waits. reset clears the sequencer and sets wall_scale to
// 16384; the texture memory is undefined until written. cfg_we writes
// wall_scale.
// ----------------------------------------------------------------------------
module raycast_wall_column_texturer_core #(
  parameter int SCREEN_HEIGHT = rwct_pkg::SCREEN_HEIGHT_DEF,
  parameter int SCREEN_WIDTH  = rwct_pkg::SCREEN_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  rwct_in_if.sink     in_ch,
  rwct_out_if.source  out_ch
);

  localparam int HW = $clog2(SCREEN_HEIGHT + 1);

  rwct_pkg::state_t state, state_next;
  rwct_pkg::div_req_t dreq;
  rwct_pkg::div_rsp_t drsp;

  logic [31:0] wall_scale;
  logic [7:0]  column;
  logic [23:0] ray_dist;
  logic [15:0] cosf;
  logic [5:0]  col_x;
  logic [1:0]  tex;
  logic [24:0] corr;
  logic [15:0] height;
  logic [7:0]  shade;
  logic [HW-1:0] hclip;
  logic [HW-1:0] start;
  logic [15:0] margin;
  logic [HW-1:0] n;
  logic [5:0]  row_y;
  logic [23:0] rdata;
  logic [40:0] prod;
  logic [31:0] shade_prod;
  logic [31:0] hq;
  logic [7:0]  r_ch, g_ch, b_ch;
  logic [HW-1:0] vtop;
  logic [HW-1:0] row;
  logic [31:0] idx_full;

  assign prod = {17'd0, ray_dist} * {25'd0, cosf};
  assign shade_prod = {17'd0, corr[24:10]} * {16'd0, rwct_pkg::SHADE_RECIP};
  assign vtop = HW'(2 * (SCREEN_HEIGHT / 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_scale <= rwct_pkg::WALL_SCALE_RST;
    end else if (cfg_we) begin
      wall_scale <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rwct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rwct_pkg::ST_IDLE:
        if (in_ch.valid && in_ch.func == rwct_pkg::FUNC_DRAW) state_next = rwct_pkg::ST_MUL;
      rwct_pkg::ST_MUL:   state_next = rwct_pkg::ST_HDIV;
      rwct_pkg::ST_HDIV:  if (drsp.done || corr == '0) state_next = rwct_pkg::ST_CLIP;
      rwct_pkg::ST_CLIP:  state_next = rwct_pkg::ST_SETUP;
      rwct_pkg::ST_SETUP:
        state_next = (height == '0) ? rwct_pkg::ST_IDLE : rwct_pkg::ST_RDIV;
      rwct_pkg::ST_RDIV:  if (drsp.done) state_next = rwct_pkg::ST_READ;
      rwct_pkg::ST_READ:  state_next = rwct_pkg::ST_EMIT;
      rwct_pkg::ST_EMIT:
        if (!out_ch.valid || out_ch.ready) begin
          state_next = (n + HW'(1) == hclip) ? rwct_pkg::ST_IDLE : rwct_pkg::ST_RDIV;
        end
      default: state_next = rwct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    case (state)
      rwct_pkg::ST_MUL: begin
        dreq.start = 1'b1;
        dreq.num   = wall_scale;
        dreq.den   = prod[39:15];
      end
      rwct_pkg::ST_SETUP, rwct_pkg::ST_EMIT: begin
        dreq.start = (state == rwct_pkg::ST_SETUP) ? (height != '0) :
                     ((!out_ch.valid || out_ch.ready) && (n + HW'(1) != hclip));
        dreq.num   = (state == rwct_pkg::ST_SETUP) ? {9'd0, 1'b0, margin, 6'd0} :
                     {9'd0, 1'b0, 16'(margin + 16'(n) + 16'd1), 6'd0};
        dreq.den   = {9'd0, height};
      end
      default: ;
    endcase
  end

  rwct_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign hq = drsp.quo;

  always_ff @(posedge clk) begin
    case (state)
      rwct_pkg::ST_IDLE:
        if (in_ch.valid) begin
          column   <= in_ch.screen_column;
          ray_dist <= in_ch.ray_distance;
          cosf     <= in_ch.cos_factor;
          col_x    <= in_ch.hit_coord[5:0];
          if (in_ch.side_vertical == 1'b0) begin
            tex <= (in_ch.quadrant < 3'd3) ? 2'd0 : 2'd1;
          end else begin
            tex <= (in_ch.quadrant == 3'd1 || in_ch.quadrant == 3'd4 ||
                    in_ch.quadrant == 3'd7) ? 2'd2 : 2'd3;
          end
        end
      rwct_pkg::ST_MUL: corr <= prod[39:15];
      rwct_pkg::ST_HDIV:
        if (corr == '0) begin
          height <= rwct_pkg::HEIGHT_MAX;
        end else if (drsp.done) begin
          height <= (hq > 32'(rwct_pkg::HEIGHT_MAX)) ? rwct_pkg::HEIGHT_MAX : hq[15:0];
        end
      rwct_pkg::ST_CLIP: begin
        shade <= (shade_prod[30:18] > 13'd255) ? 8'd255 : shade_prod[25:18];
        if (height > 16'(SCREEN_HEIGHT)) begin
          hclip  <= HW'(SCREEN_HEIGHT);
          margin <= (height - 16'(SCREEN_HEIGHT)) >> 1;
          start  <= '0;
        end else begin
          hclip  <= height[HW-1:0];
          margin <= '0;
          start  <= (vtop > height[HW-1:0]) ? HW'((vtop - height[HW-1:0]) >> 1) : '0;
        end
      end
      rwct_pkg::ST_SETUP: n <= '0;
      rwct_pkg::ST_RDIV:  if (drsp.done) row_y <= hq[5:0];
      rwct_pkg::ST_EMIT:  if (!out_ch.valid || out_ch.ready) n <= n + HW'(1);
      default: ;
    endcase
  end

  rwct_store u_store (
    .clk(clk),
    .we(state == rwct_pkg::ST_IDLE && in_ch.valid && in_ch.func == rwct_pkg::FUNC_LOAD),
    .waddr({in_ch.tex_id, in_ch.tex_addr}),
    .wdata(in_ch.texel_rgb),
    .raddr({tex, row_y, col_x}),
    .rdata(rdata)
  );

  assign in_ch.ready = (state == rwct_pkg::ST_IDLE);

  assign r_ch = (rdata[23:16] <= shade) ? 8'd0 : rdata[23:16] - shade;
  assign g_ch = (rdata[15:8]  <= shade) ? 8'd0 : rdata[15:8] - shade;
  assign b_ch = (rdata[7:0]   <= shade) ? 8'd0 : rdata[7:0] - shade;
  assign row  = start + n;
  assign idx_full = 32'(row) * 32'(SCREEN_WIDTH) + 32'(column);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == rwct_pkg::ST_EMIT && (!out_ch.valid || out_ch.ready)) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rwct_pkg::ST_EMIT && (!out_ch.valid || out_ch.ready)) begin
      out_ch.pixel_index <= idx_full[rwct_pkg::IDX_W-1:0];
      out_ch.pixel_rgba  <= {r_ch, g_ch, b_ch, rwct_pkg::ALPHA};
      out_ch.last_pixel  <= (n + HW'(1) == hclip);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state != rwct_pkg::ST_IDLE |-> !in_ch.ready)
    else $error("ready while busy");
  assert property (@(posedge clk) disable iff (rst)
    state == rwct_pkg::ST_EMIT |-> n < hclip)
    else $error("row beyond clipped height");
  assert property (@(posedge clk) disable iff (rst)
    state == rwct_pkg::ST_RDIV |-> height != '0)
    else $error("drawing zero height");

endmodule
